// ===== rtl/core/gaed_pkg.sv =====
// shared types and constants for the gamepad edge and axis event detector
package gaed_pkg;

  localparam int NUM_BUTTONS = 15;
  localparam int NUM_AXES    = 4;
  localparam int MASK_W      = 17;
  localparam int THR_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int EV_W        = 3;

  localparam logic [7:0] TRIGGER_THRESHOLD = 8'd128;

  localparam logic [THR_W-1:0] HIGH_RESET = 7'd64;
  localparam logic [THR_W-1:0] LOW_RESET  = 7'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y_HIGH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y_LOW  = 3'd7;

  // axis slots in the threshold array
  localparam int AXIS_LX = 0;
  localparam int AXIS_LY = 1;
  localparam int AXIS_RX = 2;
  localparam int AXIS_RY = 3;

  // axis event bit positions
  localparam int EV_PLUS   = 0;
  localparam int EV_MINUS  = 1;
  localparam int EV_RETURN = 2;

  // trigger bits in the press and release masks
  localparam int LT_BIT = 15;
  localparam int RT_BIT = 16;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] buttons;
    logic [7:0]             left_trigger;
    logic [7:0]             right_trigger;
    logic signed [7:0]      left_x;
    logic signed [7:0]      left_y;
    logic signed [7:0]      right_x;
    logic signed [7:0]      right_y;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] press_mask;
    logic [MASK_W-1:0] release_mask;
    logic [EV_W-1:0]   left_x_events;
    logic [EV_W-1:0]   left_y_events;
    logic [EV_W-1:0]   right_x_events;
    logic [EV_W-1:0]   right_y_events;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0] high;
    logic [THR_W-1:0] low;
  } axis_thr_t;

endpackage

// ===== rtl/core/gaed_cfg_regs.sv =====
// threshold register file for the four stick axes
module gaed_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [gaed_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gaed_pkg::THR_W-1:0]             cfg_data,
  output gaed_pkg::axis_thr_t [gaed_pkg::NUM_AXES-1:0] thr
);
  import gaed_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        thr[i].high <= HIGH_RESET;
        thr[i].low  <= LOW_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_X_HIGH:  thr[AXIS_LX].high <= cfg_data;
        REG_LEFT_X_LOW:   thr[AXIS_LX].low  <= cfg_data;
        REG_LEFT_Y_HIGH:  thr[AXIS_LY].high <= cfg_data;
        REG_LEFT_Y_LOW:   thr[AXIS_LY].low  <= cfg_data;
        REG_RIGHT_X_HIGH: thr[AXIS_RX].high <= cfg_data;
        REG_RIGHT_X_LOW:  thr[AXIS_RX].low  <= cfg_data;
        REG_RIGHT_Y_HIGH: thr[AXIS_RY].high <= cfg_data;
        REG_RIGHT_Y_LOW:  thr[AXIS_RY].low  <= cfg_data;
      endcase
    end
  end

endmodule

// ===== rtl/core/gaed_axis_detect.sv =====
// threshold crossing detector for one stick axis
module gaed_axis_detect (
  input  logic signed [7:0]            prev,
  input  logic signed [7:0]            cur,
  input  gaed_pkg::axis_thr_t          thr,
  output logic [gaed_pkg::EV_W-1:0]    events
);
  import gaed_pkg::*;

  logic signed [8:0] p;
  logic signed [8:0] c;
  logic signed [8:0] h;
  logic signed [8:0] l;
  logic signed [8:0] neg_h;
  logic signed [8:0] neg_l;

  assign p     = {prev[7], prev};
  assign c     = {cur[7], cur};
  assign h     = $signed({2'b00, thr.high});
  assign l     = $signed({2'b00, thr.low});
  assign neg_h = -h;
  assign neg_l = -l;

  always_comb begin
    events            = '0;
    events[EV_PLUS]   = (p <= h) && (c > h);
    events[EV_MINUS]  = (p >= neg_h) && (c < neg_h);
    // back into the center band from either side
    events[EV_RETURN] = ((p > l) && (c <= l)) || ((p < neg_l) && (c >= neg_l));
  end

endmodule

// ===== rtl/core/gamepad_edge_and_axis_event_detector_top.sv =====
// top level of the gamepad edge and axis event detector
// Each accepted frame yields exactly one result transfer holding the button and
// trigger edge masks and three event bits per stick axis, all relative to the
// frame accepted before it (the first frame after reset compares against all
// zeros). The block takes one frame per cycle while the output is not stalled:
// a frame is captured in an input register, compared against the stored
// previous frame through one level of compare logic and latched in the result
// register, so result valid rises only after the frame has passed both
// registers. The pipeline advances whenever the result register is empty or
// being taken, so stall on the input only rises when both stages hold data and
// the output is stalled.
// Stick thresholds are written through cfg_we/cfg_index/cfg_data, one register
// per cycle, and must only change while no frame is in flight.
module gamepad_edge_and_axis_event_detector_top (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gaed_pkg::in_item_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output gaed_pkg::out_item_t            out_data,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [gaed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gaed_pkg::THR_W-1:0]     cfg_data
);
  import gaed_pkg::*;

  // stick thresholds
  axis_thr_t [NUM_AXES-1:0] thr;

  // input register stage
  logic     s1_valid;
  in_item_t s1_frame;

  // previous frame history, updated as a frame moves into the result register
  logic [NUM_BUTTONS-1:0] prev_buttons;
  logic [7:0]             prev_lt;
  logic [7:0]             prev_rt;
  logic signed [7:0]      prev_axis [NUM_AXES];

  logic signed [7:0] cur_axis [NUM_AXES];
  logic [EV_W-1:0]   axis_ev  [NUM_AXES];

  logic      out_ready;
  logic      s1_move;
  logic      in_xfer;
  out_item_t out_next;

  logic prev_lt_above;
  logic prev_rt_above;
  logic cur_lt_above;
  logic cur_rt_above;

  gaed_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // handshake: the result register frees up when empty or being taken
  assign out_ready = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_frame <= in_data;
    end
  end

  // per-axis crossing detectors
  assign cur_axis[AXIS_LX] = s1_frame.left_x;
  assign cur_axis[AXIS_LY] = s1_frame.left_y;
  assign cur_axis[AXIS_RX] = s1_frame.right_x;
  assign cur_axis[AXIS_RY] = s1_frame.right_y;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    gaed_axis_detect u_axis_detect (
      .prev   (prev_axis[a]),
      .cur    (cur_axis[a]),
      .thr    (thr[a]),
      .events (axis_ev[a])
    );
  end

  // trigger level against the fixed threshold
  assign prev_lt_above = prev_lt > TRIGGER_THRESHOLD;
  assign prev_rt_above = prev_rt > TRIGGER_THRESHOLD;
  assign cur_lt_above  = s1_frame.left_trigger > TRIGGER_THRESHOLD;
  assign cur_rt_above  = s1_frame.right_trigger > TRIGGER_THRESHOLD;

  always_comb begin
    out_next = '0;
    out_next.press_mask[NUM_BUTTONS-1:0]   = s1_frame.buttons & ~prev_buttons;
    out_next.release_mask[NUM_BUTTONS-1:0] = prev_buttons & ~s1_frame.buttons;
    out_next.press_mask[LT_BIT]   = !prev_lt_above && cur_lt_above;
    out_next.press_mask[RT_BIT]   = !prev_rt_above && cur_rt_above;
    out_next.release_mask[LT_BIT] = prev_lt_above && !cur_lt_above;
    out_next.release_mask[RT_BIT] = prev_rt_above && !cur_rt_above;
    out_next.left_x_events  = axis_ev[AXIS_LX];
    out_next.left_y_events  = axis_ev[AXIS_LY];
    out_next.right_x_events = axis_ev[AXIS_RX];
    out_next.right_y_events = axis_ev[AXIS_RY];
  end

  // history starts as all zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_buttons <= '0;
      prev_lt      <= '0;
      prev_rt      <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_axis[i] <= '0;
      end
    end else if (s1_move) begin
      prev_buttons <= s1_frame.buttons;
      prev_lt      <= s1_frame.left_trigger;
      prev_rt      <= s1_frame.right_trigger;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_axis[i] <= cur_axis[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= out_next;
    end
  end

  // a frame leaving the input stage shows up as a result next cycle
  a_move_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("frame left input stage without producing a result");

  // nothing in flight and output free means the result register empties
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && out_ready) |=> !out_valid)
    else $error("result appeared with no frame in flight");

  // input is only held off when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free stage");

  // an edge cannot rise and fall in the same frame
  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.press_mask & out_data.release_mask) == '0))
    else $error("press and release set on the same bit");

  // history only changes when a frame moves on
  a_history_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> $stable(prev_buttons))
    else $error("button history changed without a frame moving");

endmodule
